>>> design/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg: shared types and constants for the CRC-32 frame builder
// Holds the register codes, the queue entry, the back-end step codes and the
// reflected CRC-32 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	localparam int REG_IDX_W = 2;
	localparam int BYTE_W    = 8;

	localparam logic [REG_IDX_W-1:0] REG_START_FIRST  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_SECOND = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_END_BYTE     = 2'd2;

	localparam logic [BYTE_W-1:0] START_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] START_SECOND_RST = 8'h55;
	localparam logic [BYTE_W-1:0] END_BYTE_RST     = 8'hFF;

	typedef struct packed {
		logic [BYTE_W-1:0] start_first;
		logic [BYTE_W-1:0] start_second;
		logic [BYTE_W-1:0] end_byte;
	} cfg_t;

	// One classified payload byte waiting for the back end
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              first;
		logic              last;
	} entry_t;

	// Head-of-queue handshake between front and back
	typedef struct packed {
		entry_t entry;
		logic   valid;
	} head_t;

	typedef enum logic [3:0] {
		PH_HEAD,
		PH_START1,
		PH_START2,
		PH_DATA,
		PH_END,
		PH_CRC3,
		PH_CRC2,
		PH_CRC1,
		PH_CRC0
	} phase_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> design/cfb_front.sv
// ----------------------------------------------------------------------------
// cfb_front: input side of the frame builder
// Accepts payload bytes, marks the first byte of each frame and holds the
// classified bytes in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_front #(
	parameter int DEPTH = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [cfb_pkg::BYTE_W-1:0] payload_byte,
	input  wire logic                    last_byte,
	output cfb_pkg::head_t               head,
	input  wire logic                    deq
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cfb_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             in_frame_q;
	logic             push_acc;
	cfb_pkg::entry_t  new_entry;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign push_acc = push && !full;

	always_comb begin
		new_entry.data  = payload_byte;
		new_entry.first = !in_frame_q;
		new_entry.last  = last_byte;
	end

	assign head.entry = mem_q[rd_ptr_q];
	assign head.valid = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push_acc) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			in_frame_q <= 1'b0;
		end else begin
			if (push_acc) begin
				// a last byte closes the frame; the next byte opens a new one
				in_frame_q <= !last_byte;
				wr_ptr_q   <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push_acc && !deq) begin
				count_q <= count_q + CNT_W'(1);
			end else if (deq && !push_acc) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push_acc && !deq) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted transaction not counted");

	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> head.valid)
		else $error("dequeue from empty queue");

endmodule

`default_nettype wire

>>> design/cfb_back.sv
// ----------------------------------------------------------------------------
// cfb_back: output side of the frame builder
// Steps through start bytes, payload, end byte and CRC for the head entry,
// keeps the running CRC and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cfb_pkg::cfg_t              cfg,
	input  wire cfb_pkg::head_t             head,
	output logic                            deq,
	output logic                            empty,
	input  wire logic                       pop,
	output logic [cfb_pkg::BYTE_W-1:0]      frame_byte,
	output logic                            frame_end
);

	cfb_pkg::phase_t             phase_q;
	cfb_pkg::phase_t             cur_phase;
	cfb_pkg::phase_t             next_phase;
	logic [31:0]                 crc_q;
	logic [31:0]                 crc_out;
	logic                        out_valid_q;
	logic [cfb_pkg::BYTE_W-1:0]  out_byte_q;
	logic                        out_end_q;
	logic                        out_ready;
	logic                        advance;
	logic [cfb_pkg::BYTE_W-1:0]  emit_byte;
	logic                        emit_end;
	logic                        emit_crc_tracked;

	assign out_ready = !out_valid_q || pop;
	assign advance   = head.valid && out_ready;
	assign crc_out   = crc_q ^ cfb_pkg::CRC_INIT;

	// At the head of a fresh entry, open with the start bytes only on a first byte
	always_comb begin
		if (phase_q == cfb_pkg::PH_HEAD) begin
			cur_phase = head.entry.first ? cfb_pkg::PH_START1 : cfb_pkg::PH_DATA;
		end else begin
			cur_phase = phase_q;
		end
	end

	always_comb begin
		case (cur_phase)
			cfb_pkg::PH_START1: next_phase = cfb_pkg::PH_START2;
			cfb_pkg::PH_START2: next_phase = cfb_pkg::PH_DATA;
			cfb_pkg::PH_DATA:
				next_phase = head.entry.last ? cfb_pkg::PH_END : cfb_pkg::PH_HEAD;
			cfb_pkg::PH_END:    next_phase = cfb_pkg::PH_CRC3;
			cfb_pkg::PH_CRC3:   next_phase = cfb_pkg::PH_CRC2;
			cfb_pkg::PH_CRC2:   next_phase = cfb_pkg::PH_CRC1;
			cfb_pkg::PH_CRC1:   next_phase = cfb_pkg::PH_CRC0;
			default:            next_phase = cfb_pkg::PH_HEAD;
		endcase
	end

	always_comb begin
		emit_byte        = head.entry.data;
		emit_end         = 1'b0;
		emit_crc_tracked = 1'b0;
		case (cur_phase)
			cfb_pkg::PH_START1: begin
				emit_byte        = cfg.start_first;
				emit_crc_tracked = 1'b1;
			end
			cfb_pkg::PH_START2: begin
				emit_byte        = cfg.start_second;
				emit_crc_tracked = 1'b1;
			end
			cfb_pkg::PH_DATA: begin
				emit_byte        = head.entry.data;
				emit_crc_tracked = 1'b1;
			end
			cfb_pkg::PH_END: begin
				emit_byte        = cfg.end_byte;
				emit_crc_tracked = 1'b1;
			end
			cfb_pkg::PH_CRC3: emit_byte = crc_out[31:24];
			cfb_pkg::PH_CRC2: emit_byte = crc_out[23:16];
			cfb_pkg::PH_CRC1: emit_byte = crc_out[15:8];
			cfb_pkg::PH_CRC0: begin
				emit_byte = crc_out[7:0];
				emit_end  = 1'b1;
			end
			default: emit_byte = head.entry.data;
		endcase
	end

	// Release the entry once its final byte is handed to the output register
	assign deq = advance && ((cur_phase == cfb_pkg::PH_DATA && !head.entry.last)
		|| cur_phase == cfb_pkg::PH_CRC0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= cfb_pkg::PH_HEAD;
			crc_q       <= cfb_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= next_phase;
				if (emit_crc_tracked) begin
					crc_q <= cfb_pkg::crc_byte(crc_q, emit_byte);
				end else if (cur_phase == cfb_pkg::PH_CRC0) begin
					crc_q <= cfb_pkg::CRC_INIT;
				end
			end
			if (out_ready) begin
				out_valid_q <= head.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= emit_byte;
			out_end_q  <= emit_end;
		end
	end

	assign empty      = !out_valid_q;
	assign frame_byte = out_byte_q;
	assign frame_end  = out_end_q;

	a_end_marks_crc0: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cur_phase == cfb_pkg::PH_CRC0) |=> (out_valid_q && out_end_q))
		else $error("final CRC byte lost its end flag");

	a_crc_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cur_phase == cfb_pkg::PH_CRC0) |=> crc_q == cfb_pkg::CRC_INIT)
		else $error("CRC not rearmed after frame");

	a_crc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(crc_q) && $stable(phase_q))
		else $error("sequencer moved without a transaction");

endmodule

`default_nettype wire

>>> design/crc32_frame_builder_top.sv
// ----------------------------------------------------------------------------
// crc32_frame_builder_top: CRC-32 message frame builder
// Wraps payload bytes with two start bytes, an end byte and a reflected
// CRC-32 sent most significant byte first.
// ----------------------------------------------------------------------------
//  channel   ports                                 handshake
//  input     payload_byte[7:0], last_byte          push / full
//  result    frame_byte[7:0], frame_end            empty / pop
//  config    cfg_index[1:0], cfg_data[7:0]         cfg_we
//
//  One output byte per cycle while the queue holds bytes and pop keeps the
//  output register free; a first payload byte also brings the two start bytes
//  and a last byte the end byte and four CRC bytes, set by the single byte-wide CRC update in the back-end sequencer.
//  When the queue and the output register are empty, an accepted byte is written
//  into the queue and from there into the output register before it is on the ports.
//  Reset leaves the start bytes at 0xAA, 0x55, the end byte at 0xFF and the
//  CRC at all ones; the queue holds QUEUE_DEPTH bytes so input is taken while
//  the back end inserts framing bytes or the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_frame_builder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [cfb_pkg::BYTE_W-1:0]       payload_byte,
	input  wire logic                             last_byte,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [cfb_pkg::BYTE_W-1:0]            frame_byte,
	output logic                                  frame_end,
	input  wire logic                             cfg_we,
	input  wire logic [cfb_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire logic [cfb_pkg::BYTE_W-1:0]       cfg_data
);

	cfb_pkg::cfg_t  cfg_q;
	cfb_pkg::head_t head;
	logic           deq;

	// Drop writes to indexes past the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_first  <= cfb_pkg::START_FIRST_RST;
			cfg_q.start_second <= cfb_pkg::START_SECOND_RST;
			cfg_q.end_byte     <= cfb_pkg::END_BYTE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cfb_pkg::REG_START_FIRST:  cfg_q.start_first  <= cfg_data;
				cfb_pkg::REG_START_SECOND: cfg_q.start_second <= cfg_data;
				cfb_pkg::REG_END_BYTE:     cfg_q.end_byte     <= cfg_data;
				default: ;
			endcase
		end
	end

	cfb_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.payload_byte (payload_byte),
		.last_byte    (last_byte),
		.head         (head),
		.deq          (deq)
	);

	cfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.deq        (deq),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.frame_end  (frame_end)
	);

endmodule

`default_nettype wire

>>> tb/tb_crc32_frame_builder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc32_frame_builder_top: self-checking bench for the CRC-32 frame builder
// Walks a table of directed payload bytes and register writes, then sends
// random frames under random push and pop idling. Every popped frame byte is
// compared with a local framing and CRC-32 model or a typed-in expected byte.
// ----------------------------------------------------------------------------
module tb_crc32_frame_builder_top;

	localparam int CLK_HALF       = 4;
	localparam int RANDOM_ITEMS   = 140;
	localparam int MAX_IDLE       = 18;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 8;

	// Index past the last register; writes to it must be dropped
	localparam logic [cfb_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [cfb_pkg::REG_IDX_W-1:0]   idx;
		logic [cfb_pkg::BYTE_W-1:0]      val;
		logic                            last;
		logic [1:0]                      n_typed;
		logic [3*cfb_pkg::BYTE_W-1:0]    typed;
	} stim_row_t;

	typedef struct packed {
		logic [cfb_pkg::BYTE_W-1:0] fbyte;
		logic                       fend;
	} frame_out_t;

	logic                          clk;
	logic                          arst_n;
	logic                          push;
	logic                          full;
	logic [cfb_pkg::BYTE_W-1:0]    payload_byte;
	logic                          last_byte;
	logic                          empty;
	logic                          pop;
	logic [cfb_pkg::BYTE_W-1:0]    frame_byte;
	logic                          frame_end;
	logic                          cfg_we;
	logic [cfb_pkg::REG_IDX_W-1:0] cfg_index;
	logic [cfb_pkg::BYTE_W-1:0]    cfg_data;

	// Local copy of the block's registers and framing state
	logic [cfb_pkg::BYTE_W-1:0]    sof_first;
	logic [cfb_pkg::BYTE_W-1:0]    sof_second;
	logic [cfb_pkg::BYTE_W-1:0]    eof_byte;
	logic [31:0]                   crc_run;
	logic                          mid_frame;

	frame_out_t           pending_frame_bytes[$];
	stim_row_t            dir_rows[];
	int                   mismatch_count;
	int                   idle_cycles;
	int                   stall_left;
	int                   items_sent;
	bit                   tx_rush;
	bit                   rx_rush;

	crc32_frame_builder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.payload_byte (payload_byte),
		.last_byte    (last_byte),
		.empty        (empty),
		.pop          (pop),
		.frame_byte   (frame_byte),
		.frame_end    (frame_end),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Bit-serial form of the reflected CRC-32 byte update
	function automatic logic [31:0] crc32_fold(input logic [31:0] c, input logic [7:0] b);
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ ((c[0] ^ b[i]) ? cfb_pkg::CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	function automatic stim_row_t byte_row(input logic [7:0] data, input logic last,
		input logic [1:0] n_typed, input logic [23:0] typed);
		stim_row_t r;
		r = '0;
		r.kind    = ROW_BYTE;
		r.val     = data;
		r.last    = last;
		r.n_typed = n_typed;
		r.typed   = typed;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [cfb_pkg::REG_IDX_W-1:0] idx,
		input logic [7:0] val);
		stim_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.idx  = idx;
		r.val  = val;
		return r;
	endfunction

	function automatic logic [7:0] pick_reg_value();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic queue_frame_byte(input logic [7:0] b, input logic e);
		pending_frame_bytes.push_back('{fbyte: b, fend: e});
	endtask

	task automatic queue_crc_byte(input logic [7:0] b);
		crc_run = crc32_fold(crc_run, b);
		queue_frame_byte(b, 1'b0);
	endtask

	// Frame bytes caused by one payload byte
	task automatic frame_payload_byte(input logic [7:0] data, input logic last);
		logic [31:0] crc;
		if (!mid_frame) begin
			queue_crc_byte(sof_first);
			queue_crc_byte(sof_second);
			mid_frame = 1'b1;
		end
		queue_crc_byte(data);
		if (last) begin
			queue_crc_byte(eof_byte);
			crc = crc_run ^ cfb_pkg::CRC_INIT;
			queue_frame_byte(crc[31:24], 1'b0);
			queue_frame_byte(crc[23:16], 1'b0);
			queue_frame_byte(crc[15:8], 1'b0);
			queue_frame_byte(crc[7:0], 1'b1);
			crc_run   = cfb_pkg::CRC_INIT;
			mid_frame = 1'b0;
		end
	endtask

	task automatic send_payload(input logic [7:0] data, input logic last,
		input logic [1:0] n_typed, input logic [23:0] typed);
		int gap;
		int base;
		gap = tx_rush ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push         <= 1'b1;
		payload_byte <= data;
		last_byte    <= last;
		do @(posedge clk); while (full);
		base = pending_frame_bytes.size();
		frame_payload_byte(data, last);
		// Typed-in bytes take the place of the computed ones
		for (int k = 0; k < n_typed; k++) begin
			pending_frame_bytes[base + k].fbyte = typed[23 - 8 * k -: 8];
		end
	endtask

	// Hold input until every queued frame byte has been popped
	task automatic settle_block();
		@(negedge clk) push <= 1'b0;
		while (pending_frame_bytes.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cfb_pkg::REG_IDX_W-1:0] idx,
		input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			cfb_pkg::REG_START_FIRST:  sof_first  = val;
			cfb_pkg::REG_START_SECOND: sof_second = val;
			cfb_pkg::REG_END_BYTE:     eof_byte   = val;
			default: ;
		endcase
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// Result side: check each transaction, then draw the next pop stall
	always @(posedge clk) begin
		frame_out_t want;
		if (arst_n && pop && !empty) begin
			if (pending_frame_bytes.size() == 0) begin
				$display("%0t: unexpected frame byte: expected none, actual %02h end %0b",
					$time, frame_byte, frame_end);
				mismatch_count++;
			end else begin
				want = pending_frame_bytes.pop_front();
				if (frame_byte !== want.fbyte) begin
					$display("%0t: frame_byte: expected %02h, actual %02h",
						$time, want.fbyte, frame_byte);
					mismatch_count++;
				end
				if (frame_end !== want.fend) begin
					$display("%0t: frame_end: expected %0b, actual %0b",
						$time, want.fend, frame_end);
					mismatch_count++;
				end
			end
			stall_left = rx_rush ? 0 : $urandom_range(0, MAX_IDLE);
		end else if (stall_left > 0) begin
			stall_left--;
		end
	end

	always @(negedge clk) pop <= (stall_left == 0);

	// Watchdog: abort when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else if (idle_cycles < WATCHDOG_LIMIT) begin
			idle_cycles++;
		end else begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int n_frames;
		int len;
		arst_n         = 1'b0;
		push           = 1'b0;
		payload_byte   = '0;
		last_byte      = 1'b0;
		pop            = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		sof_first      = cfb_pkg::START_FIRST_RST;
		sof_second     = cfb_pkg::START_SECOND_RST;
		eof_byte       = cfb_pkg::END_BYTE_RST;
		crc_run        = cfb_pkg::CRC_INIT;
		mid_frame      = 1'b0;
		mismatch_count = 0;
		idle_cycles    = 0;
		stall_left     = 0;
		items_sent     = 0;
		tx_rush        = 1'b0;
		rx_rush        = 1'b0;

		dir_rows = '{
			byte_row(8'h00, 1'b0, 2'd3, 24'hAA5500),
			byte_row(8'hFF, 1'b0, 2'd1, 24'hFF0000),
			byte_row(8'h80, 1'b1, 2'd1, 24'h800000),
			byte_row(8'h01, 1'b1, 2'd3, 24'hAA5501),
			reg_row(cfb_pkg::REG_START_FIRST, 8'h00),
			reg_row(cfb_pkg::REG_START_SECOND, 8'hFF),
			reg_row(cfb_pkg::REG_END_BYTE, 8'h00),
			byte_row(8'h5A, 1'b0, 2'd3, 24'h00FF5A),
			byte_row(8'hA5, 1'b1, 2'd2, 24'hA50000),
			reg_row(REG_UNUSED, 8'h12),
			byte_row(8'h00, 1'b1, 2'd3, 24'h00FF00),
			reg_row(cfb_pkg::REG_START_FIRST, 8'hFF),
			reg_row(cfb_pkg::REG_START_SECOND, 8'h00),
			reg_row(cfb_pkg::REG_END_BYTE, 8'hFF),
			byte_row(8'h7F, 1'b0, 2'd3, 24'hFF007F),
			// change registers while the frame is open
			reg_row(cfb_pkg::REG_END_BYTE, 8'h3C),
			reg_row(cfb_pkg::REG_START_FIRST, 8'h11),
			byte_row(8'hC3, 1'b0, 2'd1, 24'hC30000),
			byte_row(8'h55, 1'b1, 2'd2, 24'h553C00),
			byte_row(8'hAA, 1'b1, 2'd3, 24'h1100AA),
			reg_row(cfb_pkg::REG_START_FIRST, cfb_pkg::START_FIRST_RST),
			reg_row(cfb_pkg::REG_START_SECOND, cfb_pkg::START_SECOND_RST),
			reg_row(cfb_pkg::REG_END_BYTE, cfb_pkg::END_BYTE_RST),
			byte_row(8'h96, 1'b1, 2'd0, 24'h000000)
		};

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				settle_block();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_payload(dir_rows[i].val, dir_rows[i].last,
					dir_rows[i].n_typed, dir_rows[i].typed);
			end
		end

		while (items_sent < RANDOM_ITEMS) begin
			settle_block();
			for (int r = 0; r < 4; r++) begin
				if ($urandom_range(0, 1) == 1)
					write_reg(cfb_pkg::REG_IDX_W'(r), pick_reg_value());
			end
			tx_rush  = ($urandom_range(0, 3) == 0);
			rx_rush  = ($urandom_range(0, 3) == 0);
			n_frames = $urandom_range(2, 5);
			for (int f = 0; f < n_frames; f++) begin
				len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8);
				for (int k = 0; k < len; k++) begin
					send_payload(8'($urandom_range(0, 255)), k == len - 1, 2'd0, 24'd0);
					items_sent++;
				end
			end
			// leave a frame open across the next register writes
			if (items_sent < RANDOM_ITEMS && $urandom_range(0, 2) == 0) begin
				send_payload(8'($urandom_range(0, 255)), 1'b0, 2'd0, 24'd0);
				items_sent++;
			end
		end

		settle_block();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> files.f
design/cfb_pkg.sv
design/cfb_front.sv
design/cfb_back.sv
design/crc32_frame_builder_top.sv
tb/tb_crc32_frame_builder_top.sv
